FILE: design/rdc_pkg.sv
// Shared constants, types and helpers for the radix digit converter.
// Used by rdc_ctrl, rdc_dpath and radix_digit_converter; no dependencies.
package rdc_pkg;

  localparam int MAX_DIGITS_DEF = 32;
  localparam int VALUE_BITS_DEF = 31;

  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 7;
  localparam int BPS     = 4;  // quotient bits resolved per divider cycle

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_ALPHA  = 7'h37;  // 'A' - 10
  localparam logic [DIGIT_W-1:0] DEC_LIMIT  = 4'd10;

  typedef struct packed {
    logic start;
    logic div;
    logic emit_rd;
    logic emit_ld;
  } rdc_cmd_t;

  typedef struct packed {
    logic step_last;
    logic quot_zero;
    logic cnt_full;
    logic cnt_last;
    logic out_free;
  } rdc_sts_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_LIMIT) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_ALPHA + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

FILE: design/rdc_ctrl.sv
// Sequencer for the radix digit converter: load, divide loop, digit emission.
// Depends on rdc_pkg; drives rdc_dpath through rdc_cmd_t / rdc_sts_t.
module rdc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rdc_pkg::rdc_sts_t sts,
  output rdc_pkg::rdc_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_RD   = 4'b0100,
    S_LD   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.step_last && (sts.quot_zero || sts.cnt_full)) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_LD;
      end
      S_LD: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          state_nxt   = sts.cnt_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/rdc_dpath.sv
// Datapath: radix register, shared radix divider, digit store and output word.
// Depends on rdc_pkg; sequenced by rdc_ctrl.
module rdc_dpath #(
  parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF,
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rdc_pkg::RADIX_W-1:0]      cfg_wdata,
  input  logic [VALUE_BITS-1:0]            in_number_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rdc_pkg::DIGIT_W-1:0]      out_digit_value,
  output logic [rdc_pkg::CHAR_W-1:0]       out_digit_char,
  output logic                             out_last_digit,
  input  rdc_pkg::rdc_cmd_t                cmd,
  output rdc_pkg::rdc_sts_t                sts
);

  localparam int STEPS = (VALUE_BITS + rdc_pkg::BPS - 1) / rdc_pkg::BPS;
  localparam int QW    = STEPS * rdc_pkg::BPS;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CW    = $clog2(MAX_DIGITS + 1);
  localparam int AW    = $clog2(MAX_DIGITS);
  localparam int DW    = rdc_pkg::DIGIT_W;
  localparam int RW    = rdc_pkg::RADIX_W;

  logic [RW-1:0] radix_r;
  logic [RW-1:0] rad_eff;
  logic [QW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] step_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] mem [MAX_DIGITS];
  logic [DW-1:0] rd_data_r;
  logic          out_valid_r;
  logic [DW-1:0] out_value_r;
  logic [rdc_pkg::CHAR_W-1:0] out_char_r;
  logic          out_last_r;
  logic [RW-1:0] t;
  logic          step_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= rdc_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (radix_r < rdc_pkg::RADIX_MIN) begin
      rad_eff = rdc_pkg::RADIX_MIN;
    end else if (radix_r > rdc_pkg::RADIX_MAX) begin
      rad_eff = rdc_pkg::RADIX_MAX;
    end else begin
      rad_eff = radix_r;
    end
  end

  // restoring division, BPS quotient bits per cycle
  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    t       = '0;
    for (int i = 0; i < rdc_pkg::BPS; i++) begin
      t     = {rem_nxt, q_nxt[QW-1]};
      q_nxt = {q_nxt[QW-2:0], 1'b0};
      if (t >= rad_eff) begin
        rem_nxt  = DW'(t - rad_eff);
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[DW-1:0];
      end
    end
  end

  assign step_last = (step_r == SW'(STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r    <= '0;
      rem_r  <= '0;
      step_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.start) begin
      q_r    <= QW'(in_number_in);
      rem_r  <= '0;
      step_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.div) begin
      q_r <= q_nxt;
      if (step_last) begin
        rem_r  <= '0;
        step_r <= '0;
        cnt_r  <= cnt_r + 1'b1;
      end else begin
        rem_r  <= rem_nxt;
        step_r <= step_r + 1'b1;
      end
    end else if (cmd.emit_ld) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div && step_last) begin
      mem[cnt_r[AW-1:0]] <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_rd) begin
      rd_data_r <= mem[AW'(cnt_r - 1'b1)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_value_r <= rd_data_r;
      out_char_r  <= rdc_pkg::digit_to_char(rd_data_r);
      out_last_r  <= (cnt_r == CW'(1));
    end
  end

  assign sts.step_last = step_last;
  assign sts.quot_zero = (q_nxt == '0);
  assign sts.cnt_full  = (cnt_r == CW'(MAX_DIGITS - 1));
  assign sts.cnt_last  = (cnt_r == CW'(1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_digit_value = out_value_r;
  assign out_digit_char  = out_char_r;
  assign out_last_digit  = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_ld |-> (!out_valid_r || !out_stall))
    else $error("output word overwritten while stalled");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_rd || cmd.emit_ld) |-> (cnt_r != '0))
    else $error("digit emitted from empty store");

endmodule

FILE: design/radix_digit_converter.sv
// Top level of the radix digit converter: rdc_ctrl sequencer plus rdc_dpath.
// Depends on rdc_pkg, rdc_ctrl and rdc_dpath.
//
// Converts one VALUE_BITS-wide unsigned word into digits of the radix held in
// the cfg register (2..16, out-of-range values clamp, reset 10), emitted most
// significant first with the digit value, its ASCII char (0-9A-F) and a last
// flag; zero gives a single '0'. One word is in flight at a time. Each digit
// is resolved in the shared divider (four quotient bits per cycle) until the
// quotient is zero or the digit store is full; the stored digits are then
// read back (S_RD, then S_LD, which waits while the output is stalled).
// Write cfg only while idle.
module radix_digit_converter #(
  parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF,
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rdc_pkg::RADIX_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [VALUE_BITS-1:0]       in_number_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rdc_pkg::DIGIT_W-1:0] out_digit_value,
  output logic [rdc_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                        out_last_digit
);

  rdc_pkg::rdc_cmd_t cmd;
  rdc_pkg::rdc_sts_t sts;

  rdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rdc_dpath #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_number_in    (in_number_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digit_value (out_digit_value),
    .out_digit_char  (out_digit_char),
    .out_last_digit  (out_last_digit),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

FILE: tb/sv/radix_digit_converter_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for radix_digit_converter: sends numbers under several
// radix settings and idle patterns, predicts each digit word and checks them in order.
// Depends on rdc_pkg and the radix_digit_converter RTL.
module radix_digit_converter_test;

  localparam int NUM_W         = rdc_pkg::VALUE_BITS_DEF;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int SEGMENTS      = 8;
  localparam int SEG_ITEMS     = 40;
  localparam int REPORT_CAP    = 10;

  typedef struct {
    logic [rdc_pkg::DIGIT_W-1:0] value;
    logic [rdc_pkg::CHAR_W-1:0]  glyph;
    logic                        last;
  } digit_word_t;

  class digit_tracker;
    logic [rdc_pkg::RADIX_W-1:0] radix_reg;
    digit_word_t                 pending_digits[$];
    int                          mismatches;
    int                          numbers_seen;
    int                          digits_seen;

    function new();
      radix_reg    = rdc_pkg::RADIX_RESET;
      mismatches   = 0;
      numbers_seen = 0;
      digits_seen  = 0;
    endfunction

    function void set_radix(logic [rdc_pkg::RADIX_W-1:0] r);
      radix_reg = r;
    endfunction

    function void take_number(logic [NUM_W-1:0] n);
      logic [rdc_pkg::DIGIT_W-1:0] rem[rdc_pkg::MAX_DIGITS_DEF];
      logic [NUM_W-1:0]            q;
      int                          base;
      int                          count;
      int                          k;
      string                       glyphs;
      digit_word_t                 w;
      glyphs = "0123456789ABCDEF";
      base = radix_reg;
      if (base < rdc_pkg::RADIX_MIN) begin
        base = rdc_pkg::RADIX_MIN;
      end else if (base > rdc_pkg::RADIX_MAX) begin
        base = rdc_pkg::RADIX_MAX;
      end
      q = n;
      count = 0;
      do begin
        rem[count] = rdc_pkg::DIGIT_W'(q % base);
        q = NUM_W'(q / base);
        count++;
      end while (q != 0 && count < rdc_pkg::MAX_DIGITS_DEF);
      for (k = count - 1; k >= 0; k--) begin
        w.value = rem[k];
        w.glyph = rdc_pkg::CHAR_W'(glyphs[rem[k]]);
        w.last  = (k == 0);
        pending_digits.push_back(w);
      end
      numbers_seen++;
    endfunction

    function void match_digit(logic [rdc_pkg::DIGIT_W-1:0] v,
                              logic [rdc_pkg::CHAR_W-1:0] c, logic l);
      digit_word_t w;
      digits_seen++;
      if (pending_digits.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("unexpected digit word: v=%0d c=%0d last=%0d", v, c, l);
        return;
      end
      w = pending_digits.pop_front();
      if (v !== w.value || c !== w.glyph || l !== w.last) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("digit mismatch: expected v=%0d c=%0d last=%0d, got v=%0d c=%0d last=%0d",
                   w.value, w.glyph, w.last, v, c, l);
      end
    endfunction
  endclass

  logic                          clk             = 1'b0;
  logic                          rst_n           = 1'b0;
  logic                          cfg_we          = 1'b0;
  logic [rdc_pkg::RADIX_W-1:0]   cfg_wdata       = '0;
  logic                          in_valid        = 1'b0;
  logic                          in_stall;
  logic [NUM_W-1:0]              in_number_in    = '0;
  logic                          out_valid;
  logic                          out_stall       = 1'b0;
  logic [rdc_pkg::DIGIT_W-1:0]   out_digit_value;
  logic [rdc_pkg::CHAR_W-1:0]    out_digit_char;
  logic                          out_last_digit;

  int unsigned                   cycle_count     = 0;
  int                            snd_idle_pct    = 0;
  int                            rcv_stall_pct   = 0;
  int                            radix_writes    = 0;
  digit_tracker                  sb              = new();

  radix_digit_converter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_number_in   (in_number_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_value(out_digit_value),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(negedge clk) out_stall = ($urandom_range(0, 99) < rcv_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.match_digit(out_digit_value, out_digit_char, out_last_digit);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_number(logic [NUM_W-1:0] n);
    while (snd_idle_pct > 0 && $urandom_range(0, 99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_number_in = n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_number(n);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending_digits.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_radix(logic [rdc_pkg::RADIX_W-1:0] r);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = r;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_radix(r);
    radix_writes++;
  endtask

  function automatic logic [NUM_W-1:0] pick_number();
    logic [NUM_W-1:0] n;
    case ($urandom_range(0, 4))
      0: n = NUM_W'($urandom);
      1: n = NUM_W'($urandom_range(0, 300));
      2: n = NUM_W'($urandom >> $urandom_range(1, 31));
      3: n = {NUM_W{1'b1}} >> $urandom_range(0, NUM_W - 1);
      default: n = NUM_W'($urandom_range(0, 1));
    endcase
    return n;
  endfunction

  initial begin
    logic [rdc_pkg::RADIX_W-1:0] seg_radix[SEGMENTS];
    int                          seg;
    int                          i;
    seg_radix = '{5'd2, 5'd16, 5'd7, 5'd31, 5'd3, 5'd0, 5'd10, 5'd13};
    seg_radix[6] = rdc_pkg::RADIX_W'($urandom_range(0, 31));

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset radix is decimal
    send_number(NUM_W'(0));
    send_number(NUM_W'(9));
    send_number(NUM_W'(10));
    send_number({NUM_W{1'b1}});
    send_number(NUM_W'(1_000_000_000));
    write_radix(5'd2);
    send_number(NUM_W'(0));
    send_number(NUM_W'(1));
    send_number({NUM_W{1'b1}});
    send_number(NUM_W'(1) << (NUM_W - 1));
    write_radix(5'd16);
    send_number(NUM_W'(15));
    send_number(NUM_W'(16));
    send_number({NUM_W{1'b1}});
    send_number(NUM_W'(0));
    // out-of-range radix clamps to 2 or 16
    write_radix(5'd0);
    send_number(NUM_W'(6));
    write_radix(5'd1);
    send_number(NUM_W'(5));
    write_radix(5'd17);
    send_number(NUM_W'(255));
    write_radix(5'd31);
    send_number(NUM_W'(4095));
    write_radix(5'd3);
    send_number({NUM_W{1'b1}});

    for (seg = 0; seg < SEGMENTS; seg++) begin
      write_radix(seg_radix[seg]);
      case (seg % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 50; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 50; end
        default: begin snd_idle_pct = 10; rcv_stall_pct = 10; end
      endcase
      for (i = 0; i < SEG_ITEMS; i++) send_number(pick_number());
    end

    drain();
    $display("%0d numbers converted into %0d digit words over %0d radix writes",
             sb.numbers_seen, sb.digits_seen, radix_writes);
    $display("idle patterns: none, sender gaps, receiver stalls, light mix of both");
    if (sb.pending_digits.size() != 0)
      $display("%0d expected digit words never arrived", sb.pending_digits.size());
    if (sb.mismatches == 0 && sb.pending_digits.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/rdc_pkg.sv
design/rdc_ctrl.sv
design/rdc_dpath.sv
design/radix_digit_converter.sv
tb/sv/radix_digit_converter_test.sv
